// ===== rtl/tcgl_pkg.sv =====
package tcgl_pkg;

  typedef enum logic [1:0] {
    RK_CELL  = 2'd0,
    RK_GLYPH = 2'd1,
    RK_CLEAR = 2'd2
  } rect_kind_t;

  typedef enum logic [2:0] {
    CFG_X_MIN    = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_LINE_ADV = 3'd4,
    CFG_BASELINE = 3'd5,
    CFG_FG       = 3'd6,
    CFG_BG       = 3'd7
  } cfg_idx_t;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;

  localparam logic [7:0]  X_MIN_RST    = 8'd0;
  localparam logic [7:0]  WIDTH_RST    = 8'd160;
  localparam logic [6:0]  Y_MIN_RST    = 7'd0;
  localparam logic [6:0]  HEIGHT_RST   = 7'd80;
  localparam logic [6:0]  LINE_ADV_RST = 7'd10;
  localparam logic [6:0]  BASELINE_RST = 7'd8;
  localparam logic [23:0] FG_RST       = 24'hffffff;
  localparam logic [23:0] BG_RST       = 24'h000000;

  typedef struct packed {
    rect_kind_t  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] bm;
    logic [23:0] color;
    logic        last;
  } rect_t;

endpackage

// ===== rtl/text_cursor_glyph_layout.sv =====
// Channel  Direction  Payload
// in_      slave      tdata: char, advance, x_off, y_off, width, height, bitmap; tuser: present
// out_     master     tdata: x, y, width, height, bitmap, color; tuser: kind; tlast
// cfg_     slave      cfg_index selects the register, cfg_data holds the value
//
// One input register, then the layout logic, then the result register with a
// second slot for the glyph rectangle. A character that gives two rectangles
// sends them in turn over the single result port. The first rectangle passes
// through the input register and the result register before it is presented.
// Synchronous active-low reset: cursor at column 0, baseline row; registers at defaults.
// A stalled output holds the input register; cfg is always ready.
module text_cursor_glyph_layout #(
  parameter int MAX_WINDOW_WIDTH  = 160,
  parameter int MAX_WINDOW_HEIGHT = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [15:8] glyph_advance, [23:16] glyph_x_offset,
  // [31:24] glyph_y_offset, [39:32] glyph_width, [47:40] glyph_height,
  // [63:48] glyph_bitmap_start
  input  logic [63:0] in_tdata,
  // [0] glyph_present
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] rect_x, [15:8] rect_y, [23:16] rect_width, [31:24] rect_height,
  // [47:32] bitmap_start, [71:48] fill_color
  output logic [71:0] out_tdata,
  // [1:0] rect_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [7:0] WW_MAX = 8'(MAX_WINDOW_WIDTH);
  localparam logic [7:0] WH_MAX = 8'(MAX_WINDOW_HEIGHT);
  localparam logic [7:0] WW_RST = (MAX_WINDOW_WIDTH < 160) ? WW_MAX : tcgl_pkg::WIDTH_RST;
  localparam logic [6:0] WH_RST = (MAX_WINDOW_HEIGHT < 80) ? WH_MAX[6:0] : tcgl_pkg::HEIGHT_RST;

  logic [7:0]  wx_r, ww_r;
  logic [6:0]  wy_r, wh_r, la_r, bo_r;
  logic [23:0] fg_r, bg_r;

  logic [7:0]  cx_r, cx_nxt;
  logic [8:0]  cy_r, cy_nxt;

  logic        s1_valid_r;
  logic [63:0] s1_data_r;
  logic        s1_present_r;

  tcgl_pkg::rect_t out_r, pend_r;
  logic            out_valid_r, pend_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r <= tcgl_pkg::X_MIN_RST;
      ww_r <= WW_RST;
      wy_r <= tcgl_pkg::Y_MIN_RST;
      wh_r <= WH_RST;
      la_r <= tcgl_pkg::LINE_ADV_RST;
      bo_r <= tcgl_pkg::BASELINE_RST;
      fg_r <= tcgl_pkg::FG_RST;
      bg_r <= tcgl_pkg::BG_RST;
    end else if (cfg_valid) begin
      unique case (tcgl_pkg::cfg_idx_t'(cfg_index))
        tcgl_pkg::CFG_X_MIN:    wx_r <= cfg_data[7:0];
        tcgl_pkg::CFG_WIDTH:    ww_r <= (cfg_data[7:0] > WW_MAX) ? WW_MAX : cfg_data[7:0];
        tcgl_pkg::CFG_Y_MIN:    wy_r <= cfg_data[6:0];
        tcgl_pkg::CFG_HEIGHT:
          wh_r <= ({1'b0, cfg_data[6:0]} > WH_MAX) ? WH_MAX[6:0] : cfg_data[6:0];
        tcgl_pkg::CFG_LINE_ADV: la_r <= cfg_data[6:0];
        tcgl_pkg::CFG_BASELINE: bo_r <= cfg_data[6:0];
        tcgl_pkg::CFG_FG:       fg_r <= cfg_data;
        tcgl_pkg::CFG_BG:       bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // field split
  logic [7:0]  ch, adv, xoff, yoff, gw, gh;
  logic [15:0] bm;
  assign ch   = s1_data_r[7:0];
  assign adv  = s1_data_r[15:8];
  assign xoff = s1_data_r[23:16];
  assign yoff = s1_data_r[31:24];
  assign gw   = s1_data_r[39:32];
  assign gh   = s1_data_r[47:40];
  assign bm   = s1_data_r[63:48];

  logic is_glyph, is_lf, is_cr, is_ff, too_big, wrap, step, to_top;
  logic [7:0]         cx_a;
  logic [9:0]         cy_a, cy_b;
  logic signed [11:0] t;
  logic               cell_ok, glyph_ok, clear_ok;
  tcgl_pkg::rect_t    cell_rect, glyph_rect, clear_rect, first_rect, second_rect;
  logic [1:0]         n_rect;

  always_comb begin
    is_glyph = s1_present_r;
    is_lf    = !s1_present_r && (ch == tcgl_pkg::CH_LF);
    is_cr    = !s1_present_r && (ch == tcgl_pkg::CH_CR);
    is_ff    = !s1_present_r && (ch == tcgl_pkg::CH_FF);
    too_big  = (adv > ww_r) || (la_r > wh_r);
    wrap     = ({1'b0, cx_r} + {1'b0, adv}) > {1'b0, ww_r};
    cx_a     = (is_glyph && wrap) ? 8'd0 : cx_r;
    step     = (is_glyph && wrap) || is_lf;
    cy_a     = {1'b0, cy_r} + (step ? {3'b0, la_r} : 10'd0);
    // bottom edge: next line would start above the window or end below it
    t        = $signed({2'b0, cy_a}) + $signed({5'b0, la_r}) - $signed({5'b0, bo_r});
    to_top   = t[11] || (t > $signed({5'b0, wh_r}));
    cy_b     = to_top ? {3'b0, bo_r} : cy_a;

    cell_rect.kind  = tcgl_pkg::RK_CELL;
    cell_rect.x     = cx_a + wx_r;
    cell_rect.y     = cy_b[7:0] + {1'b0, wy_r} - {1'b0, bo_r};
    cell_rect.w     = adv;
    cell_rect.h     = {1'b0, la_r};
    cell_rect.bm    = 16'd0;
    cell_rect.color = bg_r;
    cell_rect.last  = 1'b0;

    glyph_rect.kind  = tcgl_pkg::RK_GLYPH;
    glyph_rect.x     = cx_a + wx_r + xoff;
    glyph_rect.y     = cy_b[7:0] + {1'b0, wy_r} + yoff;
    glyph_rect.w     = gw;
    glyph_rect.h     = gh;
    glyph_rect.bm    = bm;
    glyph_rect.color = fg_r;
    glyph_rect.last  = 1'b1;

    clear_rect.kind  = tcgl_pkg::RK_CLEAR;
    clear_rect.x     = wx_r;
    clear_rect.y     = {1'b0, wy_r};
    clear_rect.w     = ww_r;
    clear_rect.h     = {1'b0, wh_r};
    clear_rect.bm    = 16'd0;
    clear_rect.color = bg_r;
    clear_rect.last  = 1'b1;

    cell_ok  = is_glyph && !too_big && (adv != 8'd0) && (la_r != 7'd0);
    glyph_ok = is_glyph && !too_big && (gw != 8'd0) && (gh != 8'd0);
    clear_ok = is_ff && (ww_r != 8'd0) && (wh_r != 7'd0);

    first_rect  = glyph_rect;
    second_rect = glyph_rect;
    n_rect      = 2'd0;
    if (cell_ok && glyph_ok) begin
      first_rect = cell_rect;
      n_rect     = 2'd2;
    end else if (cell_ok) begin
      first_rect      = cell_rect;
      first_rect.last = 1'b1;
      n_rect          = 2'd1;
    end else if (glyph_ok) begin
      n_rect = 2'd1;
    end else if (clear_ok) begin
      first_rect = clear_rect;
      n_rect     = 2'd1;
    end

    cx_nxt = cx_r;
    cy_nxt = cy_r;
    if (is_glyph) begin
      if (!too_big) begin
        cx_nxt = cx_a + adv;
        cy_nxt = cy_b[8:0];
      end
    end else if (is_lf) begin
      cx_nxt = 8'd0;
      cy_nxt = cy_b[8:0];
    end else if (is_cr) begin
      cx_nxt = 8'd0;
    end else if (is_ff) begin
      cx_nxt = 8'd0;
      cy_nxt = {2'b0, bo_r};
    end
  end

  logic out_free, s1_adv;
  assign out_free  = !pend_valid_r && (!out_valid_r || out_tready);
  assign s1_adv    = s1_valid_r && ((n_rect == 2'd0) || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cx_r       <= 8'd0;
      cy_r       <= {2'b0, tcgl_pkg::BASELINE_RST};
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r    <= in_tdata;
      s1_present_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (s1_adv && (n_rect != 2'd0)) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= (n_rect == 2'd2);
    end else if (out_valid_r && out_tready) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (n_rect != 2'd0)) begin
      out_r  <= first_rect;
      pend_r <= second_rect;
    end else if (out_valid_r && out_tready && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.color, out_r.bm, out_r.h, out_r.w, out_r.y, out_r.x};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_pend_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (out_valid_r && !out_r.last))
    else $error("second rectangle pending without an open first one");

  a_pair_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && pend_valid_r) |=> (out_tvalid && out_tlast))
    else $error("second rectangle of a pair not presented as last");

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> out_valid_r)
    else $error("input register stalled with an empty output");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int WIN_W_LIMIT = 160;
  localparam int WIN_H_LIMIT = 80;
  localparam int STALL_LIMIT = 2000;

  // packs straight into in_tdata: char_code in the low byte
  typedef struct packed {
    logic [15:0] bm;
    logic [7:0]  gh;
    logic [7:0]  gw;
    logic [7:0]  yoff;
    logic [7:0]  xoff;
    logic [7:0]  adv;
    logic [7:0]  ch;
  } glyph_req_t;

  class layout_tracker;
    logic [7:0]      x_min, width;
    logic [6:0]      y_min, height, line_adv, baseline;
    logic [23:0]     fg, bg;
    logic [7:0]      cur_x;
    logic [8:0]      cur_y;
    tcgl_pkg::rect_t pending_rects[$];
    int              rects_this_char;
    int              mismatches;

    function new();
      x_min = tcgl_pkg::X_MIN_RST;
      width = tcgl_pkg::WIDTH_RST;
      y_min = tcgl_pkg::Y_MIN_RST;
      height = tcgl_pkg::HEIGHT_RST;
      line_adv = tcgl_pkg::LINE_ADV_RST;
      baseline = tcgl_pkg::BASELINE_RST;
      fg = tcgl_pkg::FG_RST;
      bg = tcgl_pkg::BG_RST;
      cur_x = '0;
      cur_y = 9'(tcgl_pkg::BASELINE_RST);
      mismatches = 0;
    endfunction

    function void set_reg(tcgl_pkg::cfg_idx_t idx, logic [23:0] v);
      case (idx)
        tcgl_pkg::CFG_X_MIN:    x_min = v[7:0];
        tcgl_pkg::CFG_WIDTH:
          width = (int'(v[7:0]) > WIN_W_LIMIT) ? 8'(WIN_W_LIMIT) : v[7:0];
        tcgl_pkg::CFG_Y_MIN:    y_min = v[6:0];
        tcgl_pkg::CFG_HEIGHT:
          height = (int'(v[6:0]) > WIN_H_LIMIT) ? 7'(WIN_H_LIMIT) : v[6:0];
        tcgl_pkg::CFG_LINE_ADV: line_adv = v[6:0];
        tcgl_pkg::CFG_BASELINE: baseline = v[6:0];
        tcgl_pkg::CFG_FG:       fg = v;
        tcgl_pkg::CFG_BG:       bg = v;
        default: ;
      endcase
    endfunction

    // back to the top line when the next line would leave the window
    function int wrap_to_top(int y);
      int t;
      t = y + int'(line_adv) - int'(baseline);
      if (t < 0 || t > int'(height)) return int'(baseline);
      return y;
    endfunction

    function void push_rect(tcgl_pkg::rect_kind_t k, int x, int y, int w, int h,
                            logic [15:0] bm, logic [23:0] col);
      tcgl_pkg::rect_t r;
      r.kind = k;
      r.x = x[7:0];
      r.y = y[7:0];
      r.w = w[7:0];
      r.h = h[7:0];
      r.bm = bm;
      r.color = col;
      r.last = 1'b1;
      if (r.w == 0 || r.h == 0) return;
      if (rects_this_char > 0) pending_rects[pending_rects.size() - 1].last = 1'b0;
      pending_rects.push_back(r);
      rects_this_char++;
    endfunction

    function void note_char(glyph_req_t g, logic present);
      int cx, cy, adv;
      rects_this_char = 0;
      cx = int'(cur_x);
      cy = int'(cur_y);
      adv = int'(g.adv);
      if (present) begin
        if (adv > int'(width) || int'(line_adv) > int'(height)) return;
        if (cx + adv > int'(width)) begin
          cx = 0;
          cy = cy + int'(line_adv);
        end
        cy = wrap_to_top(cy);
        push_rect(tcgl_pkg::RK_CELL, cx + int'(x_min),
                  cy + int'(y_min) + 256 - int'(baseline),
                  adv, int'(line_adv), '0, bg);
        push_rect(tcgl_pkg::RK_GLYPH, cx + int'(x_min) + int'(g.xoff),
                  cy + int'(y_min) + int'(g.yoff),
                  int'(g.gw), int'(g.gh), g.bm, fg);
        cur_x = 8'(cx + adv);
        cur_y = 9'(cy);
      end else if (g.ch == tcgl_pkg::CH_LF) begin
        cur_x = '0;
        cur_y = 9'(wrap_to_top(cy + int'(line_adv)));
      end else if (g.ch == tcgl_pkg::CH_CR) begin
        cur_x = '0;
      end else if (g.ch == tcgl_pkg::CH_FF) begin
        push_rect(tcgl_pkg::RK_CLEAR, int'(x_min), int'(y_min), int'(width), int'(height),
                  '0, bg);
        cur_x = '0;
        cur_y = 9'(baseline);
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_rect(tcgl_pkg::rect_t got);
      tcgl_pkg::rect_t want;
      if (pending_rects.size() == 0) begin
        report($sformatf("rect kind %0d at (%0d,%0d) with none pending",
                         got.kind, got.x, got.y));
        return;
      end
      want = pending_rects.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.x !== want.x) report($sformatf("x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y) report($sformatf("y %0d, want %0d", got.y, want.y));
      if (got.w !== want.w) report($sformatf("width %0d, want %0d", got.w, want.w));
      if (got.h !== want.h) report($sformatf("height %0d, want %0d", got.h, want.h));
      if (got.bm !== want.bm) report($sformatf("bitmap %h, want %h", got.bm, want.bm));
      if (got.color !== want.color)
        report($sformatf("color %h, want %h", got.color, want.color));
      if (got.last !== want.last) report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  layout_tracker   tracker;
  logic [23:0]     plan [8];
  int              gap_odds = 3;
  int              sink_stall_odds = 4;
  int              stall_left = 0;
  int              idle_cycles = 0;
  tcgl_pkg::rect_t seen_rect;
  glyph_req_t      item;
  logic            item_glyph;
  int              counted;

  text_cursor_glyph_layout dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("[text_cursor_glyph_layout] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_rect.kind = tcgl_pkg::rect_kind_t'(out_tuser);
      seen_rect.x = out_tdata[7:0];
      seen_rect.y = out_tdata[15:8];
      seen_rect.w = out_tdata[23:16];
      seen_rect.h = out_tdata[31:24];
      seen_rect.bm = out_tdata[47:32];
      seen_rect.color = out_tdata[71:48];
      seen_rect.last = out_tlast;
      tracker.check_rect(seen_rect);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic glyph_req_t mk(logic [7:0] ch, logic [7:0] adv, logic [7:0] xoff,
                                    logic [7:0] yoff, logic [7:0] gw, logic [7:0] gh,
                                    logic [15:0] bm);
    return '{bm: bm, gh: gh, gw: gw, yoff: yoff, xoff: xoff, adv: adv, ch: ch};
  endfunction

  task send_char(input glyph_req_t g, input logic present);
    in_tdata <= g;
    in_tuser <= present;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_char(g, present);
  endtask

  task pause_sender();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // hold off requests until every pending rectangle has come out
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_rects.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_reg(tcgl_pkg::cfg_idx_t'(i), plan[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick(int lo, int hi, int fmax);
    case ($urandom_range(0, 11))
      0: return lo;
      1: return hi;
      2: return fmax;
      3: return $urandom_range(0, fmax);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [23:0] junk_above(int bits);
    return 24'($urandom) << bits;
  endfunction

  task pick_settings();
    int la;
    plan[tcgl_pkg::CFG_X_MIN] = junk_above(8) | 24'(pick(0, 159, 255));
    plan[tcgl_pkg::CFG_WIDTH] = junk_above(8) | 24'(pick(8, 160, 255));
    plan[tcgl_pkg::CFG_Y_MIN] = junk_above(7) | 24'(pick(0, 79, 127));
    plan[tcgl_pkg::CFG_HEIGHT] = junk_above(7) | 24'(pick(8, 80, 127));
    la = pick(4, 16, 127);
    plan[tcgl_pkg::CFG_LINE_ADV] = junk_above(7) | 24'(la);
    plan[tcgl_pkg::CFG_BASELINE] = junk_above(7) | 24'(pick(0, la, 127));
    plan[tcgl_pkg::CFG_FG] = 24'($urandom);
    plan[tcgl_pkg::CFG_BG] = 24'($urandom);
  endtask

  task next_item(output glyph_req_t g, output logic present);
    int r;
    r = $urandom_range(0, 99);
    g = {$urandom, $urandom};
    present = 1'b0;
    if (r < 70) begin
      present = 1'b1;
      g.adv = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 60))
                                            : 8'($urandom_range(1, 12));
      g.xoff = 8'($urandom_range(0, 4) - 1);
      g.yoff = 8'(0 - $urandom_range(0, 12));
      g.gw = 8'($urandom_range(0, g.adv));
      g.gh = 8'($urandom_range(0, 12));
    end else if (r < 85) begin
      case ($urandom_range(0, 5))
        0, 1, 2: g.ch = tcgl_pkg::CH_LF;
        3, 4:    g.ch = tcgl_pkg::CH_CR;
        default: g.ch = tcgl_pkg::CH_FF;
      endcase
    end else if (r < 93) begin
      present = 1'($urandom_range(0, 1));
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_char(mk(8'h41, 8, 0, 8'hf9, 6, 7, 16'h0010), 1'b1);
    pause_sender();
    send_char(mk(8'h20, 5, 0, 0, 0, 0, 16'h0000), 1'b1);
    send_char(mk(8'h27, 0, 1, 8'hf8, 2, 3, 16'h0123), 1'b1);
    send_char(mk(8'h00, 0, 0, 0, 0, 0, 16'hffff), 1'b1);
    pause_sender();
    send_char(mk(8'h57, 161, 0, 0, 4, 4, 16'h0042), 1'b1);
    send_char(mk(8'hff, 160, 8'h7f, 8'h80, 255, 255, 16'hffff), 1'b1);
    repeat (7) begin
      send_char(mk(tcgl_pkg::CH_LF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);
      pause_sender();
    end
    send_char(mk(tcgl_pkg::CH_CR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff), 1'b0);
    send_char(mk(tcgl_pkg::CH_FF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);
    send_char(mk(tcgl_pkg::CH_LF, 4, 8'h80, 8'h7f, 3, 3, 16'h8000), 1'b1);
    send_char(mk(8'h41, 4, 0, 0, 3, 3, 16'h1234), 1'b0);
    send_char(mk(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff), 1'b0);

    drain();
    plan[tcgl_pkg::CFG_X_MIN] = 24'd255;
    plan[tcgl_pkg::CFG_WIDTH] = 24'd255;
    plan[tcgl_pkg::CFG_Y_MIN] = 24'd127;
    plan[tcgl_pkg::CFG_HEIGHT] = 24'd127;
    plan[tcgl_pkg::CFG_LINE_ADV] = 24'd80;
    plan[tcgl_pkg::CFG_BASELINE] = 24'd80;
    plan[tcgl_pkg::CFG_FG] = 24'h000000;
    plan[tcgl_pkg::CFG_BG] = 24'hffffff;
    program_regs();
    send_char(mk(8'h4d, 160, 8'h80, 8'h7f, 1, 1, 16'h0777), 1'b1);
    send_char(mk(tcgl_pkg::CH_LF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);
    send_char(mk(tcgl_pkg::CH_FF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);

    drain();
    plan[tcgl_pkg::CFG_X_MIN] = 24'd0;
    plan[tcgl_pkg::CFG_WIDTH] = 24'd0;
    plan[tcgl_pkg::CFG_Y_MIN] = 24'd0;
    plan[tcgl_pkg::CFG_HEIGHT] = 24'd0;
    plan[tcgl_pkg::CFG_LINE_ADV] = 24'd0;
    plan[tcgl_pkg::CFG_BASELINE] = 24'd0;
    plan[tcgl_pkg::CFG_FG] = 24'h5a5a5a;
    plan[tcgl_pkg::CFG_BG] = 24'ha5a5a5;
    program_regs();
    send_char(mk(8'h2e, 0, 2, 8'hfe, 4, 4, 16'h0abc), 1'b1);
    send_char(mk(tcgl_pkg::CH_FF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);
    send_char(mk(tcgl_pkg::CH_LF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);

    // baseline far below the cursor, line height taller than the window
    drain();
    plan[tcgl_pkg::CFG_X_MIN] = 24'd159;
    plan[tcgl_pkg::CFG_WIDTH] = 24'd160;
    plan[tcgl_pkg::CFG_Y_MIN] = 24'd79;
    plan[tcgl_pkg::CFG_HEIGHT] = 24'd1;
    plan[tcgl_pkg::CFG_LINE_ADV] = 24'd2;
    plan[tcgl_pkg::CFG_BASELINE] = 24'd127;
    plan[tcgl_pkg::CFG_FG] = 24'hffffff;
    plan[tcgl_pkg::CFG_BG] = 24'h123456;
    program_regs();
    send_char(mk(tcgl_pkg::CH_LF, 0, 0, 0, 0, 0, 16'h0000), 1'b0);
    send_char(mk(8'h61, 3, 0, 0, 2, 2, 16'h0005), 1'b1);

    for (int phase = 0; phase < 10; phase++) begin
      drain();
      pick_settings();
      program_regs();
      if (phase == 9) begin
        gap_odds = 0;
        sink_stall_odds = 0;
      end else begin
        gap_odds = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 12);
        sink_stall_odds = (phase % 4 == 2) ? 0 : ((phase % 2 == 0) ? 3 : 10);
      end
      counted = 0;
      while (counted < 55) begin
        next_item(item, item_glyph);
        send_char(item, item_glyph);
        counted++;
        pause_sender();
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending_rects.size() == 0)
      $display("[text_cursor_glyph_layout] OK");
    else
      $display("[text_cursor_glyph_layout] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcgl_pkg.sv
rtl/text_cursor_glyph_layout.sv
sim/testbench.sv
